/* rtl/core/ida_pkg.sv */
`timescale 1ns / 1ps

package ida_pkg;

	// field widths of the transaction payloads
	localparam int unsigned IDENT_W      = 10;
	localparam int unsigned PAYLOAD_IO_W = 32;
	localparam int unsigned IDENT_SPAN   = 1 << IDENT_W;

	// bitmap memory word
	localparam int unsigned MAP_WORD_W = 32;

	// parameter defaults
	localparam int unsigned DEF_ENTRIES       = 1024;
	localparam int unsigned DEF_PAYLOAD_WIDTH = 32;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_ACCESS,
		ST_APPLY,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/ida_req_if.sv */
`timescale 1ns / 1ps

interface ida_req_if;
	import ida_pkg::*;

	logic                    valid;
	logic                    ready;
	cmd_t                    cmd;
	logic [IDENT_W-1:0]      ident;
	logic [PAYLOAD_IO_W-1:0] payload_in;

	modport source (output valid, cmd, ident, payload_in, input ready);
	modport sink (input valid, cmd, ident, payload_in, output ready);
endinterface

/* rtl/core/ida_rsp_if.sv */
`timescale 1ns / 1ps

interface ida_rsp_if;
	import ida_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [IDENT_W-1:0]      ident_out;
	logic [PAYLOAD_IO_W-1:0] payload_out;
	logic                    ok;

	modport source (output valid, ident_out, payload_out, ok, input ready);
	modport sink (input valid, ident_out, payload_out, ok, output ready);
endinterface

/* rtl/core/id_allocator_with_payload_table_unit.sv */
`timescale 1ns / 1ps
// Identifier allocator with a payload word per identifier.
// req channel carries cmd (alloc, free, write, read), ident and payload_in;
// rsp channel returns exactly one transaction per request: ident_out,
// payload_out and ok. Identifier 0 is never granted and is the failure value.
// Alloc grants the lowest free identifier from 1 upward and zeroes its payload;
// free, write and read act only on a nonzero identifier that is in use.
// Alloc scans the bitmap from word 0 upward, reading one 32-bit bitmap word per
// cycle, and grants from the first word that holds a free identifier.
// Free, write and read step through memory read, update and result; a zero or
// out-of-range ident goes straight to the result.
// One request is processed at a time; req.ready is high only while idle, in the
// cycle after the result is loaded into the output register.
// A finished response waits in an output register, so the next request may
// be accepted while rsp is stalled; the block then holds that request's
// result until the output register is taken.
// Reset: after arst_n releases, a clearing pass zeroes the bitmap one word
// per cycle, with req.ready low.
// The payload memory is not cleared; alloc zeroes each word it grants.
module id_allocator_with_payload_table_unit #(
	parameter int unsigned ENTRIES       = ida_pkg::DEF_ENTRIES,
	parameter int unsigned PAYLOAD_WIDTH = ida_pkg::DEF_PAYLOAD_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	ida_req_if.sink    req,
	ida_rsp_if.source  rsp
);
	import ida_pkg::*;

	localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned BIT_W      = $clog2(MAP_WORD_W);
	localparam int unsigned WORDS      = (ENTRIES + MAP_WORD_W - 1) / MAP_WORD_W;
	localparam int unsigned WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned LIMIT      = (ENTRIES < IDENT_SPAN) ? ENTRIES : IDENT_SPAN;
	localparam int unsigned SCAN_WORDS = (LIMIT + MAP_WORD_W - 1) / MAP_WORD_W;
	localparam int unsigned RP_W       = $clog2(SCAN_WORDS + 1);
	localparam int unsigned LAST_BITS  = LIMIT - (SCAN_WORDS - 1) * MAP_WORD_W;
	localparam logic [MAP_WORD_W-1:0] LAST_MASK =
		MAP_WORD_W'((64'd1 << LAST_BITS) - 64'd1);

	// control state
	state_t state_q, state_d;
	logic [WADDR_W-1:0] clr_ptr_q;
	logic [RP_W-1:0]    rd_ptr_q;
	logic               chk_vld_q;
	logic [WADDR_W-1:0] chk_ptr_q;
	logic               out_vld_q;

	// request and result registers
	cmd_t                    cmd_q;
	logic [IDENT_W-1:0]      ident_q;
	logic [PAYLOAD_IO_W-1:0] pdata_q;
	logic [IDENT_W-1:0]      res_ident_q;
	logic [PAYLOAD_IO_W-1:0] res_payload_q;
	logic                    res_ok_q;
	logic [IDENT_W-1:0]      out_ident_q;
	logic [PAYLOAD_IO_W-1:0] out_payload_q;
	logic                    out_ok_q;

	// memories
	logic [MAP_WORD_W-1:0]    map_mem [WORDS];
	logic [MAP_WORD_W-1:0]    map_rdata_q;
	logic [PAYLOAD_WIDTH-1:0] pl_mem [ENTRIES];
	logic [PAYLOAD_WIDTH-1:0] pl_rdata_q;

	// memory port controls
	logic                     map_we;
	logic [WADDR_W-1:0]       map_waddr;
	logic [WADDR_W-1:0]       map_raddr;
	logic [MAP_WORD_W-1:0]    map_wdata;
	logic                     pl_we;
	logic [IDX_W-1:0]         pl_addr;
	logic [PAYLOAD_WIDTH-1:0] pl_wdata;

	// result capture
	logic                    res_we;
	logic [IDENT_W-1:0]      res_ident_d;
	logic [PAYLOAD_IO_W-1:0] res_payload_d;
	logic                    res_ok_d;
	logic                    out_load;
	logic                    accept;

	// datapath terms
	logic                    req_ident_ok;
	logic [31:0]             ident_ext;
	logic [IDX_W-1:0]        id_idx;
	logic [WADDR_W-1:0]      id_word;
	logic [BIT_W-1:0]        id_bit;
	logic [MAP_WORD_W-1:0]   id_onehot;
	logic                    in_use;
	logic                    rd_lt;
	logic                    last_word;
	logic [MAP_WORD_W-1:0]   word_mask;
	logic [MAP_WORD_W-1:0]   free_vec;
	logic                    found;
	logic                    scan_end;
	logic [BIT_W-1:0]        free_bit;
	logic [31:0]             found_id32;
	logic [63:0]             pl_rdata_wide;

	assign accept = req.valid && req.ready;

	// request decode
	assign req_ident_ok = (req.ident != '0) && (32'(req.ident) < ENTRIES);
	assign ident_ext    = 32'(ident_q);
	assign id_idx       = ident_ext[IDX_W-1:0];
	assign id_word      = ident_ext[WADDR_W+BIT_W-1:BIT_W];
	assign id_bit       = ident_q[BIT_W-1:0];
	assign id_onehot    = MAP_WORD_W'(1) << id_bit;
	assign in_use       = map_rdata_q[id_bit];

	// scan word check: mask off identifier 0 and bits past the grantable range
	assign rd_lt     = rd_ptr_q < RP_W'(SCAN_WORDS);
	assign last_word = chk_ptr_q == WADDR_W'(SCAN_WORDS - 1);
	always_comb begin
		word_mask = '1;
		if (chk_ptr_q == '0) begin
			word_mask[0] = 1'b0;
		end
		if (last_word) begin
			word_mask = word_mask & LAST_MASK;
		end
	end
	assign free_vec = ~map_rdata_q & word_mask;
	assign found    = chk_vld_q && (free_vec != '0);
	assign scan_end = chk_vld_q && last_word;

	// lowest free bit of the checked word
	always_comb begin
		free_bit = '0;
		for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				free_bit = BIT_W'(b);
			end
		end
	end
	assign found_id32 = 32'({chk_ptr_q, free_bit});

	assign pl_rdata_wide = 64'(pl_rdata_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_ptr_q == WADDR_W'(WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					if (req.cmd == CMD_ALLOC) begin
						state_d = ST_SCAN;
					end else if (req_ident_ok) begin
						state_d = ST_ACCESS;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (found || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_ACCESS: state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready     = 1'b0;
		map_we        = 1'b0;
		map_waddr     = id_word;
		map_wdata     = map_rdata_q;
		map_raddr     = id_word;
		pl_we         = 1'b0;
		pl_addr       = id_idx;
		pl_wdata      = PAYLOAD_WIDTH'(pdata_q);
		res_we        = 1'b0;
		res_ident_d   = '0;
		res_payload_d = '0;
		res_ok_d      = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_ptr_q;
				map_wdata = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				res_we    = req.valid;
			end
			ST_SCAN: begin
				map_raddr = WADDR_W'(rd_ptr_q);
				if (found) begin
					map_we      = 1'b1;
					map_waddr   = chk_ptr_q;
					map_wdata   = map_rdata_q | (MAP_WORD_W'(1) << free_bit);
					pl_we       = 1'b1;
					pl_addr     = found_id32[IDX_W-1:0];
					pl_wdata    = '0;
					res_we      = 1'b1;
					res_ident_d = found_id32[IDENT_W-1:0];
					res_ok_d    = 1'b1;
				end
			end
			ST_ACCESS: begin
				map_raddr = id_word;
			end
			ST_APPLY: begin
				if (in_use) begin
					res_we   = 1'b1;
					res_ok_d = 1'b1;
					case (cmd_q)
						CMD_FREE: begin
							map_we    = 1'b1;
							map_wdata = map_rdata_q & ~id_onehot;
						end
						CMD_WRITE: begin
							pl_we = 1'b1;
						end
						CMD_READ: begin
							res_payload_d = pl_rdata_wide[PAYLOAD_IO_W-1:0];
						end
						default: begin
							res_ok_d = 1'b0;
						end
					endcase
				end
			end
			ST_DONE: begin
				out_load = !out_vld_q || rsp.ready;
			end
			default: begin
				res_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_ptr_q <= '0;
			rd_ptr_q  <= '0;
			chk_vld_q <= 1'b0;
			chk_ptr_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			if (accept) begin
				rd_ptr_q <= '0;
			end else if (state_q == ST_SCAN && rd_lt) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			chk_vld_q <= (state_q == ST_SCAN) && rd_lt && !found;
			chk_ptr_q <= WADDR_W'(rd_ptr_q);
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request, result and output payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			ident_q <= req.ident;
			pdata_q <= req.payload_in;
		end
		if (res_we) begin
			res_ident_q   <= res_ident_d;
			res_payload_q <= res_payload_d;
			res_ok_q      <= res_ok_d;
		end
		if (out_load) begin
			out_ident_q   <= res_ident_q;
			out_payload_q <= res_payload_q;
			out_ok_q      <= res_ok_q;
		end
	end

	// used-bitmap memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rdata_q <= map_mem[map_raddr];
	end

	// payload memory
	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_addr] <= pl_wdata;
		end
		pl_rdata_q <= pl_mem[pl_addr];
	end

	// response channel
	assign rsp.valid       = out_vld_q;
	assign rsp.ident_out   = out_ident_q;
	assign rsp.payload_out = out_payload_q;
	assign rsp.ok          = out_ok_q;

	// a nonzero identifier only comes from a successful alloc with zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_ident_q != '0) |-> out_ok_q && (out_payload_q == '0))
		else $error("granted identifier without ok or with payload");

	// granted identifiers stay inside the grantable range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_ident_q != '0) |-> 32'(out_ident_q) < LIMIT)
		else $error("granted identifier out of range");

	// the scan only checks words that hold grantable identifiers
	assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_q |-> (state_q == ST_SCAN) && (32'(chk_ptr_q) < SCAN_WORDS))
		else $error("scan check outside the scanned words");

	// bitmap is written only by the clearing pass, a grant or a free
	assert property (@(posedge clk) disable iff (!arst_n)
		map_we |-> (state_q == ST_CLEAR) || (state_q == ST_SCAN)
			|| ((state_q == ST_APPLY) && (cmd_q == CMD_FREE)))
		else $error("unexpected bitmap write");

	// a finished result is not lost while the output register is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_vld_q && !rsp.ready |=> state_q == ST_DONE)
		else $error("result dropped under stall");
endmodule
